// ===== sv/deadline_event_scheduler_macros.svh =====
// Assertion macros shared by the scheduler checkers.
`ifndef DEADLINE_EVENT_SCHEDULER_MACROS_SVH
`define DEADLINE_EVENT_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/des_pkg.sv =====
// Shared types and codes for the deadline event scheduler.
package des_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int RES_W       = $clog2(MAX_RESULTS);

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_CANCEL = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      KIND_ADDED      = 3'd0,
      KIND_DUP        = 3'd1,
      KIND_CANCELLED  = 3'd2,
      KIND_NOT_SCHED  = 3'd3,
      KIND_FIRED      = 3'd4,
      KIND_NOTHING    = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic slot_valid;
   } scan_ctl_type;

endpackage

// ===== sv/des_scan.sv =====
// Shared minimum finder: one deadline comparator fed one slot per cycle.
module des_scan #(
   parameter int EVENT_SLOTS = 16,
   parameter int TIME_BITS   = 48,
   localparam int SLOT_W     = $clog2(EVENT_SLOTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  des_pkg::scan_ctl_type ctl,
   input  logic [SLOT_W-1:0]     rd_idx,
   input  logic [TIME_BITS-1:0]  rd_deadline,
   output logic                  best_found,
   output logic [SLOT_W-1:0]     best_idx,
   output logic [TIME_BITS-1:0]  best_deadline
);

   logic                 found_ff;
   logic [SLOT_W-1:0]    idx_ff;
   logic [TIME_BITS-1:0] deadline_ff;
   logic                 take;

   // strict less-than keeps the lowest index on equal deadlines
   assign take = ctl.load && ctl.slot_valid && (!found_ff || (rd_deadline < deadline_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         idx_ff      <= rd_idx;
         deadline_ff <= rd_deadline;
      end
   end

   assign best_found    = found_ff;
   assign best_idx      = idx_ff;
   assign best_deadline = deadline_ff;

endmodule

// ===== sv/deadline_event_scheduler.sv =====
// Top level of the deadline event scheduler: slot table, sequencer and result register.
//
//   channel   ports                                         direction  handshake
//   req       req_action, req_event_handle, req_time_value  in         req_valid / req_stall
//   rsp       rsp_kind ... rsp_last (7 fields)              out        rsp_valid / rsp_stall
//
// Every input item runs at least one full pass over the slot table: a read of every slot,
// then the drain state and the decide state, through the single deadline comparator.
// An add, cancel or unused code makes a single pass; a tick that fires k >= 1 events
// runs a further pass after each fired event, to find the next one.
// Reset is synchronous and clears all valid marks and the count; no clearing pass.
// req_stall is high from acceptance until the last result transfers; rsp_stall holds a result.
module deadline_event_scheduler #(
   parameter int EVENT_SLOTS = 16,
   parameter int TIME_BITS   = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_event_handle,
   input  logic [47:0] req_time_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_fired_handle,
   output logic [47:0] rsp_fired_time,
   output logic        rsp_next_valid,
   output logic [47:0] rsp_next_deadline,
   output logic [4:0]  rsp_pending_count,
   output logic        rsp_last
);

   import des_pkg::*;

   localparam int SLOT_W = $clog2(EVENT_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(EVENT_SLOTS - 1);
   localparam logic [RES_W-1:0]  LAST_RESULT = RES_W'(MAX_RESULTS - 1);

   state_type state_ff, state_in;

   logic [EVENT_SLOTS-1:0] valid_ff, valid_in;
   logic [TIME_BITS-1:0]   deadline_mem [EVENT_SLOTS];
   logic [4:0]             count_ff, count_in;
   logic [SLOT_W-1:0]      addr_ff, addr_in;

   logic                 rd_load_ff;
   logic                 rd_sv_ff;
   logic [SLOT_W-1:0]    rd_idx_ff;
   logic [TIME_BITS-1:0] rd_dl_ff;

   logic                 tick_ff, tick_in;
   logic [2:0]           kind_ff, kind_in;
   logic [3:0]           hdl_ff, hdl_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic                 fire_pend_ff, fire_pend_in;
   logic [SLOT_W-1:0]    fire_idx_ff, fire_idx_in;
   logic [TIME_BITS-1:0] fire_dl_ff, fire_dl_in;
   logic [RES_W-1:0]     nres_ff, nres_in;

   logic [2:0]  out_kind_ff, out_kind_in;
   logic [3:0]  out_handle_ff, out_handle_in;
   logic [47:0] out_ftime_ff, out_ftime_in;
   logic        out_nv_ff, out_nv_in;
   logic [47:0] out_nd_ff, out_nd_in;
   logic [4:0]  out_cnt_ff, out_cnt_in;
   logic        out_last_ff, out_last_in;
   logic        out_load;

   logic                 mem_we;
   logic [TIME_BITS-1:0] tval;
   logic [SLOT_W-1:0]    hidx;
   logic                 in_rng;
   logic                 hit;
   logic                 due;
   logic [4:0]           count_dec;

   scan_ctl_type         scan_ctl;
   logic                 best_found;
   logic [SLOT_W-1:0]    best_idx;
   logic [TIME_BITS-1:0] best_dl;

   des_scan #(
      .EVENT_SLOTS (EVENT_SLOTS),
      .TIME_BITS   (TIME_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .ctl           (scan_ctl),
      .rd_idx        (rd_idx_ff),
      .rd_deadline   (rd_dl_ff),
      .best_found    (best_found),
      .best_idx      (best_idx),
      .best_deadline (best_dl)
   );

   assign tval      = TIME_BITS'(req_time_value);
   assign hidx      = SLOT_W'(req_event_handle);
   assign in_rng    = int'(req_event_handle) < EVENT_SLOTS;
   assign hit       = in_rng && valid_ff[hidx];
   assign due       = best_found && (best_dl <= time_ff);
   assign count_dec = (count_ff != 5'd0) ? (count_ff - 5'd1) : count_ff;

   // slot deadline store: one write port, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (mem_we) begin
         deadline_mem[hidx] <= tval;
      end
      rd_dl_ff  <= deadline_mem[addr_ff];
      rd_idx_ff <= addr_ff;
      rd_sv_ff  <= valid_ff[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         addr_ff      <= '0;
         rd_load_ff   <= 1'b0;
         tick_ff      <= 1'b0;
         fire_pend_ff <= 1'b0;
         nres_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         rd_load_ff   <= (state_ff == ST_SCAN);
         tick_ff      <= tick_in;
         fire_pend_ff <= fire_pend_in;
         nres_ff      <= nres_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      hdl_ff        <= hdl_in;
      time_ff       <= time_in;
      fire_idx_ff   <= fire_idx_in;
      fire_dl_ff    <= fire_dl_in;
      out_kind_ff   <= out_kind_in;
      out_handle_ff <= out_handle_in;
      out_ftime_ff  <= out_ftime_in;
      out_nv_ff     <= out_nv_in;
      out_nd_ff     <= out_nd_in;
      out_cnt_ff    <= out_cnt_in;
      out_last_ff   <= out_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      tick_in       = tick_ff;
      kind_in       = kind_ff;
      hdl_in        = hdl_ff;
      time_in       = time_ff;
      fire_pend_in  = fire_pend_ff;
      fire_idx_in   = fire_idx_ff;
      fire_dl_in    = fire_dl_ff;
      nres_in       = nres_ff;
      mem_we        = 1'b0;
      out_load      = 1'b0;
      out_kind_in   = out_kind_ff;
      out_handle_in = out_handle_ff;
      out_ftime_in  = out_ftime_ff;
      out_nv_in     = out_nv_ff;
      out_nd_in     = out_nd_ff;
      out_cnt_in    = out_cnt_ff;
      out_last_in   = out_last_ff;
      scan_ctl.clear      = 1'b0;
      scan_ctl.load       = rd_load_ff;
      scan_ctl.slot_valid = rd_sv_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hdl_in         = req_event_handle;
               time_in        = tval;
               tick_in        = 1'b0;
               fire_pend_in   = 1'b0;
               nres_in        = '0;
               addr_in        = '0;
               scan_ctl.clear = 1'b1;
               state_in       = ST_SCAN;
               case (req_action)
                  ACT_TICK: begin
                     tick_in = 1'b1;
                     kind_in = KIND_NOTHING;
                  end
                  ACT_ADD: begin
                     if (!in_rng || hit) begin
                        kind_in = KIND_DUP;
                     end else begin
                        kind_in        = KIND_ADDED;
                        mem_we         = 1'b1;
                        valid_in[hidx] = 1'b1;
                        count_in       = count_ff + 5'd1;
                     end
                  end
                  ACT_CANCEL: begin
                     if (!hit) begin
                        kind_in = KIND_NOT_SCHED;
                     end else begin
                        kind_in        = KIND_CANCELLED;
                        valid_in[hidx] = 1'b0;
                        count_in       = count_dec;
                     end
                  end
                  default: begin
                     kind_in = KIND_NOTHING;
                     hdl_in  = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (addr_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!tick_ff) begin
               out_load      = 1'b1;
               out_kind_in   = kind_ff;
               out_handle_in = hdl_ff;
               out_ftime_in  = '0;
               out_last_in   = 1'b1;
            end else if (fire_pend_ff) begin
               // fired slot is gone; this scan gives the state after it
               out_load      = 1'b1;
               out_kind_in   = KIND_FIRED;
               out_handle_in = 4'(fire_idx_ff);
               out_ftime_in  = 48'(fire_dl_ff);
               out_last_in   = !due || (nres_ff == LAST_RESULT);
            end else if (due) begin
               valid_in[best_idx] = 1'b0;
               count_in           = count_dec;
               fire_pend_in       = 1'b1;
               fire_idx_in        = best_idx;
               fire_dl_in         = best_dl;
               addr_in            = '0;
               scan_ctl.clear     = 1'b1;
               state_in           = ST_SCAN;
            end else begin
               out_load      = 1'b1;
               out_kind_in   = KIND_NOTHING;
               out_handle_in = '0;
               out_ftime_in  = '0;
               out_last_in   = 1'b1;
            end
            if (out_load) begin
               out_nv_in  = best_found;
               out_nd_in  = best_found ? 48'(best_dl) : '0;
               out_cnt_in = count_ff;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (out_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  // next due candidate is still held by the scan unit
                  fire_pend_in = 1'b0;
                  nres_in      = nres_ff + 1'b1;
                  state_in     = ST_DECIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_EMIT);
   assign rsp_kind          = out_kind_ff;
   assign rsp_fired_handle  = out_handle_ff;
   assign rsp_fired_time    = out_ftime_ff;
   assign rsp_next_valid    = out_nv_ff;
   assign rsp_next_deadline = out_nd_ff;
   assign rsp_pending_count = out_cnt_ff;
   assign rsp_last          = out_last_ff;

endmodule

// ===== sv/des_checker.sv =====
// Port-level checks for the deadline event scheduler, bound to the top level.
`include "deadline_event_scheduler_macros.svh"

module des_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_action,
   input logic [3:0]  req_event_handle,
   input logic [47:0] req_time_value,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_kind,
   input logic [3:0]  rsp_fired_handle,
   input logic [47:0] rsp_fired_time,
   input logic        rsp_next_valid,
   input logic [47:0] rsp_next_deadline,
   input logic [4:0]  rsp_pending_count,
   input logic        rsp_last
);

   import des_pkg::*;

   `DES_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_action) && $stable(req_event_handle) && $stable(req_time_value),
      "stalled request changed")

   `DES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_fired_handle) && $stable(rsp_fired_time) && $stable(rsp_last),
      "stalled result changed")

   `DES_ASSERT_IMPL(a_one_item, clock, reset, rsp_valid, req_stall,
      "input taken while a result is pending")

   `DES_ASSERT_IMPL(a_empty_table, clock, reset, rsp_valid && !rsp_next_valid,
      rsp_pending_count == 5'd0 && rsp_next_deadline == 48'd0,
      "empty table reports a deadline or a count")

   `DES_ASSERT_IMPL(a_fire_order, clock, reset,
      rsp_valid && rsp_kind == KIND_FIRED && rsp_next_valid,
      rsp_next_deadline >= rsp_fired_time,
      "remaining deadline earlier than fired one")

endmodule

bind deadline_event_scheduler des_checker u_des_checker (.*);
